// File: hdl/kf_pkg.sv
// Shared constants, types and the arithmetic helper of the position and velocity Kalman filter.
package kf_pkg;

    localparam int DEFAULT_FRAC_BITS = 16;
    localparam int DATA_W = 32;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MEAS_NOISE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Q_POS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Q_CROSS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Q_VEL      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MOTION_POS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MOTION_VEL = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_VAR   = 3'd7;

    // Datapath operand selectors.
    localparam logic [4:0] SEL_ZERO  = 5'd0;
    localparam logic [4:0] SEL_Z     = 5'd1;
    localparam logic [4:0] SEL_POS   = 5'd2;
    localparam logic [4:0] SEL_VEL   = 5'd3;
    localparam logic [4:0] SEL_P00   = 5'd4;
    localparam logic [4:0] SEL_P01   = 5'd5;
    localparam logic [4:0] SEL_P11   = 5'd6;
    localparam logic [4:0] SEL_TMP   = 5'd7;
    localparam logic [4:0] SEL_K0    = 5'd8;
    localparam logic [4:0] SEL_K1    = 5'd9;
    localparam logic [4:0] SEL_DT    = 5'd10;
    localparam logic [4:0] SEL_R     = 5'd11;
    localparam logic [4:0] SEL_QP    = 5'd12;
    localparam logic [4:0] SEL_QC    = 5'd13;
    localparam logic [4:0] SEL_QV    = 5'd14;
    localparam logic [4:0] SEL_PRD   = 5'd15;
    localparam logic [4:0] SEL_Y     = 5'd16;
    localparam logic [4:0] SEL_MP    = 5'd17;
    localparam logic [4:0] SEL_MV    = 5'd18;

    // Operation codes of the arithmetic unit.
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;

    // Destination codes.
    localparam logic [3:0] DST_NONE = 4'd0;
    localparam logic [3:0] DST_POS  = 4'd1;
    localparam logic [3:0] DST_VEL  = 4'd2;
    localparam logic [3:0] DST_P00  = 4'd3;
    localparam logic [3:0] DST_P01  = 4'd4;
    localparam logic [3:0] DST_P11  = 4'd5;
    localparam logic [3:0] DST_TMP  = 4'd6;
    localparam logic [3:0] DST_Y    = 4'd7;
    localparam logic [3:0] DST_S    = 4'd8;
    localparam logic [3:0] DST_PRD  = 4'd9;

    // One micro step: operation, operand selectors, destination.
    typedef struct packed {
        logic       valid;
        logic [1:0] op;
        logic [4:0] sel_a;
        logic [4:0] sel_b;
        logic [3:0] dst;
    } t_cmd;

    // Controller to datapath commands.
    typedef struct packed {
        t_cmd cmd;
        logic load;       // capture input item, apply restart
        logic div_start;  // start divider on a selected numerator
        logic div_sel;    // 0 numerator P00, 1 numerator P01
        logic div_store;  // write divider result to K0 or K1
        logic clr_sat;
    } t_dp_ctrl;

    // Datapath to controller status.
    typedef struct packed {
        logic div_busy;
    } t_dp_stat;

    // Clip a 34 bit signed value to 32 bits.
    function automatic logic [32:0] clip34(input logic signed [33:0] v);
        logic [32:0] r;
        if (v > 34'sd2147483647) r = {1'b1, 32'h7FFF_FFFF};
        else if (v < -34'sd2147483648) r = {1'b1, 32'h8000_0000};
        else r = {1'b0, v[31:0]};
        return r;
    endfunction

endpackage

// File: hdl/kf_div.sv
// Serial restoring divider with round to nearest, ties away from zero.
module kf_div
    import kf_pkg::*;
#(
    parameter int FRAC_BITS = DEFAULT_FRAC_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic signed [31:0] i_num,
    input  logic signed [31:0] i_den,
    output logic              o_busy,
    output logic [31:0]       o_quot,
    output logic              o_sat
);
    localparam int NW = 32 + FRAC_BITS;   // dividend width
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_num, n_num;
    logic [32:0]   r_rem, n_rem;
    logic [NW-1:0] r_q, n_q;
    logic [32:0]   r_den, n_den;
    logic          r_neg, n_neg;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_busy, n_busy;
    logic [33:0]   w_trial;
    logic [NW:0]   w_round;
    logic signed [NW+1:0] w_signed;

    // Magnitudes of operands, with the shifted numerator, then one restoring step per quotient bit.
    always_comb begin
        logic [32:0] ma;
        logic [32:0] md;
        n_num  = r_num;
        n_rem  = r_rem;
        n_q    = r_q;
        n_den  = r_den;
        n_neg  = r_neg;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        ma = i_num[31] ? 33'(-$signed({i_num[31], i_num})) : {1'b0, i_num};
        md = i_den[31] ? 33'(-$signed({i_den[31], i_den})) : {1'b0, i_den};
        w_trial = {r_rem, r_num[NW-1]} - {1'b0, r_den};
        if (i_start) begin
            n_num  = NW'({ma[31:0], {FRAC_BITS{1'b0}}}) | (NW'(ma[32]) << (NW - 1));
            n_den  = md;
            n_rem  = '0;
            n_q    = '0;
            n_neg  = i_num[31] ^ i_den[31];
            n_cnt  = CW'(NW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            // One quotient bit per cycle.
            n_num = {r_num[NW-2:0], 1'b0};
            if (!w_trial[33]) begin
                n_rem = w_trial[32:0];
                n_q   = {r_q[NW-2:0], 1'b1};
            end else begin
                n_rem = {r_rem[31:0], r_num[NW-1]};
                n_q   = {r_q[NW-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) n_busy = 1'b0;
        end
    end

    // Final rounding: remainder doubled compared with divisor; sign applied and result saturated to 32 bits.
    always_comb begin
        logic [33:0] rem2;
        rem2 = {r_rem, 1'b0};
        w_round = {1'b0, r_q} + ((rem2 >= {1'b0, r_den}) ? (NW+1)'(1) : '0);
        w_signed = r_neg ? -$signed({1'b0, w_round}) : $signed({1'b0, w_round});
        if (w_signed > (NW+2)'(64'sd2147483647)) begin
            o_quot = 32'h7FFF_FFFF;
            o_sat  = 1'b1;
        end else if (w_signed < -(NW+2)'(64'sd2147483648)) begin
            o_quot = 32'h8000_0000;
            o_sat  = 1'b1;
        end else begin
            o_quot = w_signed[31:0];
            o_sat  = 1'b0;
        end
    end

    assign o_busy = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_num <= n_num;
        r_rem <= n_rem;
        r_q   <= n_q;
        r_den <= n_den;
        r_neg <= n_neg;
    end
endmodule

// File: hdl/kf_datapath.sv
// Filter state, configuration registers, shared multiply and add unit, divider.
module kf_datapath
    import kf_pkg::*;
#(
    parameter int FRAC_BITS = DEFAULT_FRAC_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic signed [31:0] i_measurement,
    input  logic        i_restart,
    input  t_dp_ctrl    i_ctrl,
    output t_dp_stat    o_stat,
    output logic [31:0] o_pos,
    output logic [31:0] o_vel,
    output logic [31:0] o_p00,
    output logic [31:0] o_p01,
    output logic [31:0] o_p11,
    output logic        o_sat
);
    localparam logic [31:0] INIT_VAR_RST =
        (64'd1000 << FRAC_BITS) > 64'h7FFF_FFFF ? 32'h7FFF_FFFF : 32'(64'd1000 << FRAC_BITS);
    localparam logic [31:0] ONE = 32'(64'd1 << FRAC_BITS);

    logic [31:0] r_dt, r_r, r_qp, r_qc, r_qv, r_mp, r_mv, r_iv;
    logic [31:0] r_pos, r_vel, r_p00, r_p01, r_p11;
    logic [31:0] r_z, r_y, r_s, r_tmp, r_k0, r_k1, r_prd;
    logic        r_sat;
    logic signed [31:0] w_a, w_b;
    logic [32:0] w_res;
    logic signed [63:0] w_prod;
    logic signed [64:0] w_sh;
    logic        w_div_busy;
    logic [31:0] w_quot;
    logic        w_div_sat;

    // Operand selection.
    function automatic logic [31:0] pick(input logic [4:0] s, input logic [31:0] pos,
        input logic [31:0] vel, input logic [31:0] p00, input logic [31:0] p01,
        input logic [31:0] p11, input logic [31:0] tmp, input logic [31:0] k0,
        input logic [31:0] k1, input logic [31:0] dt, input logic [31:0] z,
        input logic [31:0] rr, input logic [31:0] qp, input logic [31:0] qc,
        input logic [31:0] qv, input logic [31:0] prd, input logic [31:0] y,
        input logic [31:0] mp, input logic [31:0] mv);
        logic [31:0] v;
        unique case (s)
            SEL_ZERO: v = '0;
            SEL_Z:    v = z;
            SEL_POS:  v = pos;
            SEL_VEL:  v = vel;
            SEL_P00:  v = p00;
            SEL_P01:  v = p01;
            SEL_P11:  v = p11;
            SEL_TMP:  v = tmp;
            SEL_K0:   v = k0;
            SEL_K1:   v = k1;
            SEL_DT:   v = dt;
            SEL_R:    v = rr;
            SEL_QP:   v = qp;
            SEL_QC:   v = qc;
            SEL_QV:   v = qv;
            SEL_PRD:  v = prd;
            SEL_Y:    v = y;
            SEL_MP:   v = mp;
            SEL_MV:   v = mv;
            default:  v = '0;
        endcase
        return v;
    endfunction

    // Operands A and B of the shared unit.
    always_comb begin
        w_a = pick(i_ctrl.cmd.sel_a, r_pos, r_vel, r_p00, r_p01, r_p11, r_tmp, r_k0,
                   r_k1, r_dt, r_z, r_r, r_qp, r_qc, r_qv, r_prd, r_y, r_mp, r_mv);
        w_b = pick(i_ctrl.cmd.sel_b, r_pos, r_vel, r_p00, r_p01, r_p11, r_tmp, r_k0,
                   r_k1, r_dt, r_z, r_r, r_qp, r_qc, r_qv, r_prd, r_y, r_mp, r_mv);
    end

    // Shared arithmetic: one 32 by 32 multiply, add or subtract a step.
    always_comb begin
        w_prod = w_a * w_b;
        w_sh   = ($signed({w_prod[63], w_prod}) + 65'sd1 * $signed({1'b0, ONE >> 1}))
                 >>> FRAC_BITS;
        unique case (i_ctrl.cmd.op)
            OP_ADD:  w_res = clip34(34'(w_a) + 34'(w_b));
            OP_SUB:  w_res = clip34(34'(w_a) - 34'(w_b));
            OP_MUL: begin
                if (w_sh > 65'sd2147483647) w_res = {1'b1, 32'h7FFF_FFFF};
                else if (w_sh < -65'sd2147483648) w_res = {1'b1, 32'h8000_0000};
                else w_res = {1'b0, w_sh[31:0]};
            end
            default: w_res = '0;
        endcase
    end

    kf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_ctrl.div_start),
        .i_num   (i_ctrl.div_sel ? r_p01 : r_p00),
        .i_den   (r_s),
        .o_busy  (w_div_busy),
        .o_quot  (w_quot),
        .o_sat   (w_div_sat)
    );

    assign o_stat.div_busy = w_div_busy;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt <= ONE;
            r_r  <= ONE;
            r_qp <= '0;
            r_qc <= '0;
            r_qv <= '0;
            r_mp <= '0;
            r_mv <= '0;
            r_iv <= INIT_VAR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_TIME_STEP:  r_dt <= i_cfg_data;
                REG_MEAS_NOISE: r_r  <= {1'b0, i_cfg_data[30:0]};
                REG_Q_POS:      r_qp <= {1'b0, i_cfg_data[30:0]};
                REG_Q_CROSS:    r_qc <= i_cfg_data;
                REG_Q_VEL:      r_qv <= {1'b0, i_cfg_data[30:0]};
                REG_MOTION_POS: r_mp <= i_cfg_data;
                REG_MOTION_VEL: r_mv <= i_cfg_data;
                REG_INIT_VAR:   r_iv <= {1'b0, i_cfg_data[30:0]};
                default: ;
            endcase
        end
    end

    // Filter state and scratch registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_vel <= '0;
            r_p00 <= INIT_VAR_RST;
            r_p01 <= '0;
            r_p11 <= INIT_VAR_RST;
            r_sat <= 1'b0;
        end else begin
            if (i_ctrl.clr_sat) r_sat <= 1'b0;
            if (i_ctrl.load) begin
                r_z <= i_measurement;
                if (i_restart) begin
                    r_pos <= '0;
                    r_vel <= '0;
                    r_p00 <= r_iv;
                    r_p01 <= '0;
                    r_p11 <= r_iv;
                end
            end
            if (i_ctrl.div_store) begin
                if (r_s == '0) begin
                    r_k0  <= '0;
                    r_k1  <= '0;
                    r_sat <= 1'b1;
                end else begin
                    if (i_ctrl.div_sel) r_k1 <= w_quot;
                    else r_k0 <= w_quot;
                    if (w_div_sat) r_sat <= 1'b1;
                end
            end
            if (i_ctrl.cmd.valid) begin
                if (w_res[32]) r_sat <= 1'b1;
                unique case (i_ctrl.cmd.dst)
                    DST_NONE: ;
                    DST_POS:  r_pos <= w_res[31:0];
                    DST_VEL:  r_vel <= w_res[31:0];
                    DST_P00:  r_p00 <= w_res[31:0];
                    DST_P01:  r_p01 <= w_res[31:0];
                    DST_P11:  r_p11 <= w_res[31:0];
                    DST_TMP:  r_tmp <= w_res[31:0];
                    DST_Y:    r_y   <= w_res[31:0];
                    DST_S:    r_s   <= w_res[31:0];
                    DST_PRD:  r_prd <= w_res[31:0];
                    default: ;
                endcase
            end
        end
    end

    assign o_pos = r_pos;
    assign o_vel = r_vel;
    assign o_p00 = r_p00;
    assign o_p01 = r_p01;
    assign o_p11 = r_p11;
    assign o_sat = r_sat;
endmodule

// File: hdl/kf_ctrl.sv
// Sequencer that steps the datapath through update and prediction.
module kf_ctrl
    import kf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_ctrl o_ctrl
);
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PRE   = 3'd1;
    localparam logic [2:0] ST_DIV0  = 3'd2;
    localparam logic [2:0] ST_DIV1  = 3'd3;
    localparam logic [2:0] ST_POST  = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0] r_state, n_state;
    logic [4:0] r_step, n_step;
    logic       r_div_go, n_div_go;
    t_cmd       w_cmd;

    function automatic t_cmd mk(input logic [1:0] op, input logic [4:0] a,
                                input logic [4:0] b, input logic [3:0] d);
        t_cmd c;
        c.valid = 1'b1;
        c.op = op;
        c.sel_a = a;
        c.sel_b = b;
        c.dst = d;
        return c;
    endfunction

    // Micro program after the gains: K times y, covariance and prediction.
    always_comb begin
        w_cmd = '0;
        unique case (r_step)
            5'd0:  w_cmd = mk(OP_MUL, SEL_K0,  SEL_Y,    DST_PRD);   // k0*y
            5'd1:  w_cmd = mk(OP_ADD, SEL_POS, SEL_PRD,  DST_POS);
            5'd2:  w_cmd = mk(OP_MUL, SEL_K1,  SEL_Y,    DST_PRD);   // k1*y
            5'd3:  w_cmd = mk(OP_ADD, SEL_VEL, SEL_PRD,  DST_VEL);
            5'd4:  w_cmd = mk(OP_MUL, SEL_K1,  SEL_P01,  DST_PRD);   // k1*p01 old
            5'd5:  w_cmd = mk(OP_SUB, SEL_P11, SEL_PRD,  DST_P11);
            5'd6:  w_cmd = mk(OP_MUL, SEL_K0,  SEL_P01,  DST_PRD);
            5'd7:  w_cmd = mk(OP_SUB, SEL_P01, SEL_PRD,  DST_P01);
            5'd8:  w_cmd = mk(OP_MUL, SEL_K0,  SEL_P00,  DST_PRD);
            5'd9:  w_cmd = mk(OP_SUB, SEL_P00, SEL_PRD,  DST_P00);
            5'd10: w_cmd = mk(OP_MUL, SEL_DT,  SEL_VEL,  DST_PRD);
            5'd11: w_cmd = mk(OP_ADD, SEL_POS, SEL_PRD,  DST_POS);
            5'd12: w_cmd = mk(OP_ADD, SEL_POS, SEL_MP,   DST_POS);   // + motion_pos
            5'd13: w_cmd = mk(OP_MUL, SEL_DT,  SEL_P11,  DST_PRD);
            5'd14: w_cmd = mk(OP_ADD, SEL_P01, SEL_PRD,  DST_TMP);   // t
            5'd15: w_cmd = mk(OP_MUL, SEL_DT,  SEL_P01,  DST_PRD);
            5'd16: w_cmd = mk(OP_ADD, SEL_P00, SEL_PRD,  DST_P00);
            5'd17: w_cmd = mk(OP_MUL, SEL_DT,  SEL_TMP,  DST_PRD);
            5'd18: w_cmd = mk(OP_ADD, SEL_P00, SEL_PRD,  DST_P00);
            5'd19: w_cmd = mk(OP_ADD, SEL_P00, SEL_QP,   DST_P00);
            5'd20: w_cmd = mk(OP_ADD, SEL_TMP, SEL_QC,   DST_P01);
            5'd21: w_cmd = mk(OP_ADD, SEL_P11, SEL_QV,   DST_P11);
            5'd22: w_cmd = mk(OP_ADD, SEL_VEL, SEL_MV,   DST_VEL);   // + motion_vel
            default: w_cmd = '0;
        endcase
    end

    // State sequencing.
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_div_go = 1'b0;
        o_ctrl  = '0;
        o_in_ready  = (r_state == ST_IDLE);
        o_out_valid = (r_state == ST_OUT);
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_ctrl.load    = 1'b1;
                    o_ctrl.clr_sat = 1'b1;
                    n_state = ST_PRE;
                    n_step  = '0;
                end
            end
            ST_PRE: begin
                // y = z - pos, then S = P00 + R.
                if (r_step == 5'd0) begin
                    o_ctrl.cmd = mk(OP_SUB, SEL_Z, SEL_POS, DST_Y);
                    n_step = 5'd1;
                end else begin
                    o_ctrl.cmd = mk(OP_ADD, SEL_P00, SEL_R, DST_S);
                    n_state = ST_DIV0;
                    n_div_go = 1'b1;
                end
            end
            ST_DIV0: begin
                if (r_div_go) begin
                    o_ctrl.div_start = 1'b1;
                    o_ctrl.div_sel   = 1'b0;
                end else if (!i_stat.div_busy) begin
                    o_ctrl.div_store = 1'b1;
                    o_ctrl.div_sel   = 1'b0;
                    n_state  = ST_DIV1;
                    n_div_go = 1'b1;
                end
            end
            ST_DIV1: begin
                if (r_div_go) begin
                    o_ctrl.div_start = 1'b1;
                    o_ctrl.div_sel   = 1'b1;
                end else if (!i_stat.div_busy) begin
                    o_ctrl.div_store = 1'b1;
                    o_ctrl.div_sel   = 1'b1;
                    n_state = ST_POST;
                    n_step  = '0;
                end
            end
            ST_POST: begin
                o_ctrl.cmd = w_cmd;
                if (r_step == 5'd22) begin
                    n_state = ST_OUT;
                end
                n_step = r_step + 1'b1;
            end
            ST_OUT: begin
                if (i_out_ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_step   <= '0;
            r_div_go <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_div_go <= n_div_go;
        end
    end
endmodule

// File: hdl/kalman_filter_pos_vel.sv
// Top level of the two-state position and velocity Kalman filter.
// o_valid rises after the input transfer once the states PRE, DIV0, DIV1 and POST have run;
// one item at a time, so no new item is taken until the result has been transferred.
// The two gain divisions run on one bit-serial divider, which takes most of the processing time.
// Synchronous active-low reset restores register defaults and the initial filter state.
module kalman_filter_pos_vel
    import kf_pkg::*;
#(
    parameter int FRAC_BITS = DEFAULT_FRAC_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic signed [31:0] i_measurement,
    input  logic        i_restart,
    output logic        o_valid,
    input  logic        i_ready,
    output logic signed [31:0] o_pos_est,
    output logic signed [31:0] o_vel_est,
    output logic signed [31:0] o_var_pos,
    output logic signed [31:0] o_cov_pos_vel,
    output logic signed [31:0] o_var_vel,
    output logic        o_saturated
);
    t_dp_ctrl w_ctrl;
    t_dp_stat w_stat;

    kf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_stat      (w_stat),
        .o_ctrl      (w_ctrl)
    );

    kf_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_measurement (i_measurement),
        .i_restart     (i_restart),
        .i_ctrl        (w_ctrl),
        .o_stat        (w_stat),
        .o_pos         (o_pos_est),
        .o_vel         (o_vel_est),
        .o_p00         (o_var_pos),
        .o_p01         (o_cov_pos_vel),
        .o_p11         (o_var_vel),
        .o_sat         (o_saturated)
    );
endmodule

// File: hdl/kf_checker.sv
// Port-level checker for the Kalman filter, bound to the top level.
module kf_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_ready,
    input logic o_valid,
    input logic i_ready
);
    // A result waits until its transfer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid) else $error("result dropped");
    // No input is taken while a result is pending.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("input taken with result pending");
    // A result never follows its input in the next cycle.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_valid) else $error("result too early");
    // After a result transfer the block is ready again.
    a_ready_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready |=> o_ready) else $error("not ready after result");
endmodule

bind kalman_filter_pos_vel kf_checker u_kf_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready)
);
